// File: sv/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the spectrum fold/downsample block: register
// indexes, reset values, the command passed from front to back, FSM states.
// ----------------------------------------------------------------------------
package sfd_pkg;

    // Default build sizes
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_COEF_BITS  = 32;

    // Fixed field widths
    localparam int SIZE_W     = 7;
    localparam int POS_W      = 6;
    localparam int COEF_W     = 32;
    localparam int SCALE_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_IN_WIDTH   = 3'd0;
    localparam t_cfg_idx CFG_IN_HEIGHT  = 3'd1;
    localparam t_cfg_idx CFG_OUT_WIDTH  = 3'd2;
    localparam t_cfg_idx CFG_OUT_HEIGHT = 3'd3;
    localparam t_cfg_idx CFG_SCALE      = 3'd4;

    // Register reset values
    localparam logic [SIZE_W-1:0]  RST_IN_WIDTH   = 7'd64;
    localparam logic [SIZE_W-1:0]  RST_IN_HEIGHT  = 7'd64;
    localparam logic [SIZE_W-1:0]  RST_OUT_WIDTH  = 7'd32;
    localparam logic [SIZE_W-1:0]  RST_OUT_HEIGHT = 7'd32;
    localparam logic [SCALE_W-1:0] RST_SCALE      = 17'd16384;

    // Request modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Frame sizes as programmed
    typedef struct packed {
        logic [SIZE_W-1:0] in_width;
        logic [SIZE_W-1:0] in_height;
        logic [SIZE_W-1:0] out_width;
        logic [SIZE_W-1:0] out_height;
    } t_frame;

    // Work item handed from front to back
    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_READ,
        CMD_ERROR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [SIZE_W-1:0] col0;
        logic [SIZE_W-1:0] col1;
        logic [SIZE_W-1:0] row0;
        logic [SIZE_W-1:0] row1;
        logic              fold_col;
        logic              fold_row;
        logic [COEF_W-1:0] coef_re;
        logic [COEF_W-1:0] coef_im;
    } t_cmd;

    // Back end sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DRAIN,
        ST_MUL,
        ST_RND
    } t_back_state;

endpackage

// File: sv/sfd_in_if.sv
// ----------------------------------------------------------------------------
// sfd_in_if
// Request channel: load or read requests with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfd_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [31:0] coef_re;
    logic [31:0] coef_im;

    modport source (output valid, mode, col, row, coef_re, coef_im, input ready);
    modport sink   (input valid, mode, col, row, coef_re, coef_im, output ready);
endinterface

// File: sv/sfd_out_if.sv
// ----------------------------------------------------------------------------
// sfd_out_if
// Result channel: output coefficients with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_re;
    logic [31:0] out_im;
    logic        coord_error;
    logic        saturated;

    modport source (output valid, out_re, out_im, coord_error, saturated, input ready);
    modport sink   (input valid, out_re, out_im, coord_error, saturated, output ready);
endinterface

// File: sv/spectrum_fold_downsample.sv
// ----------------------------------------------------------------------------
// spectrum_fold_downsample
// Fourier-domain crop with Nyquist folding: loads an input spectrum into a
// store and returns scaled, saturated coefficients of the cropped spectrum.
// ----------------------------------------------------------------------------
// Usage:
//  - i_in_ch carries requests. Mode load writes coef_re/coef_im at (col, row)
//    of the input frame; loads outside the input size are dropped. Mode read
//    asks for the output coefficient at (col, row) of the output frame.
//  - o_out_ch returns one result per read request and none per load.
//  - Sizes and the Q16 scale are set through i_cfg_we/i_cfg_idx/i_cfg_data,
//    only while no request is in flight.
//  - A read gathering 1, 2 or 4 store bins reads them from the single-port
//    store, one bin a cycle, then passes the drain, the split multiply and
//    the round/saturate stage; an out-of-frame read goes straight to the result
//    register. The back end takes no new command until a read has passed
//    rounding and loaded the result register; loads go straight into the store.
//  - A two-entry queue sits between request classification and the back end,
//    and the result register frees the back end once the sink takes a result.
//  - A stalled sink holds the result; requests keep queueing until full.
//  - Reset loads the register defaults and empties queue and result register.
//    The store is not cleared: read only bins loaded since the sizes were set.
// ----------------------------------------------------------------------------
module spectrum_fold_downsample
    import sfd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int COEF_BITS  = DEF_COEF_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sfd_in_if.sink                i_in_ch,
    sfd_out_if.source             o_out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_frame             r_frame;
    logic [SCALE_W-1:0] r_scale;
    logic               q_push, q_pop, q_full, q_empty;
    t_cmd               q_in_cmd, q_out_cmd;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame.in_width   <= RST_IN_WIDTH;
            r_frame.in_height  <= RST_IN_HEIGHT;
            r_frame.out_width  <= RST_OUT_WIDTH;
            r_frame.out_height <= RST_OUT_HEIGHT;
            r_scale            <= RST_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IN_WIDTH:   r_frame.in_width   <= i_cfg_data[SIZE_W-1:0];
                CFG_IN_HEIGHT:  r_frame.in_height  <= i_cfg_data[SIZE_W-1:0];
                CFG_OUT_WIDTH:  r_frame.out_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_OUT_HEIGHT: r_frame.out_height <= i_cfg_data[SIZE_W-1:0];
                CFG_SCALE:      r_scale            <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Request classifier
    sfd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_in_ch  (i_in_ch),
        .i_frame  (r_frame),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_in_cmd)
    );

    // Command queue
    sfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_out_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Store, gather and scaling
    sfd_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COEF_BITS  (COEF_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_cmd   (q_out_cmd),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_scale   (r_scale),
        .o_out_ch  (o_out_ch)
    );

endmodule

// File: sv/sfd_front.sv
// ----------------------------------------------------------------------------
// sfd_front
// Request classifier: clamps the frame sizes, drops out-of-frame loads and
// maps read coordinates onto the input bins, including Nyquist folding.
// ----------------------------------------------------------------------------
module sfd_front
    import sfd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    sfd_in_if.sink     i_in_ch,
    input  t_frame     i_frame,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_cmd       o_q_cmd
);

    localparam logic [SIZE_W-1:0] MAXW_S = (MAX_WIDTH  > 127) ? 7'd127 : SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAXH_S = (MAX_HEIGHT > 127) ? 7'd127 : SIZE_W'(MAX_HEIGHT);

    logic [SIZE_W-1:0] iw, ih, ow, oh, hx, hy, col, row;
    logic              in_frame, out_frame;

    // Effective sizes
    always_comb begin
        iw = (i_frame.in_width == '0) ? 7'd1 :
             (i_frame.in_width > MAXW_S) ? MAXW_S : i_frame.in_width;
        ih = (i_frame.in_height == '0) ? 7'd1 :
             (i_frame.in_height > MAXH_S) ? MAXH_S : i_frame.in_height;
        ow = (i_frame.out_width == '0) ? 7'd1 :
             (i_frame.out_width > iw) ? iw : i_frame.out_width;
        oh = (i_frame.out_height == '0) ? 7'd1 :
             (i_frame.out_height > ih) ? ih : i_frame.out_height;
        hx = SIZE_W'((8'(ow) + 8'd1) >> 1);
        hy = SIZE_W'((8'(oh) + 8'd1) >> 1);
    end

    assign col       = {1'b0, i_in_ch.col};
    assign row       = {1'b0, i_in_ch.row};
    assign in_frame  = (col < iw) && (row < ih);
    assign out_frame = (col < ow) && (row < oh);

    // Handshake: take a request whenever the queue has room
    assign i_in_ch.ready = !i_q_full;

    // Classify and build the command
    always_comb begin
        o_q_cmd          = '0;
        o_q_cmd.coef_re  = i_in_ch.coef_re;
        o_q_cmd.coef_im  = i_in_ch.coef_im;
        o_q_push         = 1'b0;
        if (i_in_ch.mode == MODE_LOAD) begin
            o_q_cmd.kind = CMD_WRITE;
            o_q_cmd.col0 = col;
            o_q_cmd.row0 = row;
            o_q_push     = i_in_ch.valid && !i_q_full && in_frame;
        end else begin
            o_q_push = i_in_ch.valid && !i_q_full;
            if (!out_frame) begin
                o_q_cmd.kind = CMD_ERROR;
            end else begin
                o_q_cmd.kind     = CMD_READ;
                o_q_cmd.col0     = (col < hx) ? col : col + iw - ow;
                o_q_cmd.row0     = (row < hy) ? row : row + ih - oh;
                o_q_cmd.col1     = ow >> 1;
                o_q_cmd.row1     = oh >> 1;
                o_q_cmd.fold_col = !ow[0] && (ow < iw) && (col == (ow >> 1));
                o_q_cmd.fold_row = !oh[0] && (oh < ih) && (row == (oh >> 1));
            end
        end
    end

endmodule

// File: sv/sfd_queue.sv
// ----------------------------------------------------------------------------
// sfd_queue
// Two-entry command queue decoupling the classifier from the back end.
// ----------------------------------------------------------------------------
module sfd_queue
    import sfd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_slot[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wr_ptr] <= i_cmd;
    end

`ifndef ASSERT_OFF
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("command popped from empty queue");
`endif

endmodule

// File: sv/sfd_back.sv
// ----------------------------------------------------------------------------
// sfd_back
// Back end: owns the single-port coefficient store, gathers up to four bins
// per read, scales by the Q16 factor, rounds, saturates and holds the result.
// ----------------------------------------------------------------------------
module sfd_back
    import sfd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int COEF_BITS  = DEF_COEF_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_q_cmd,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  logic [SCALE_W-1:0] i_scale,
    sfd_out_if.source          o_out_ch
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int AW    = CW + RW;
    localparam int DEPTH = 1 << AW;
    localparam int CB    = COEF_BITS;
    localparam int SW    = CB + 2;      // sum of four terms
    localparam int HW    = SW - 17;     // upper slice of the sum
    localparam int PW    = SW + 18;     // scaled product
    localparam int QW    = PW - 16;     // after the Q16 shift
    localparam logic signed [QW-1:0] SAT_MAX = QW'((64'sd1 <<< (CB - 1)) - 64'sd1);
    localparam logic signed [QW-1:0] SAT_MIN = -SAT_MAX - QW'(1);
    localparam logic [PW-1:0]        RND_HALF = PW'(32768);

    t_back_state          r_state, n_state;
    t_cmd                 r_cmd, cur;
    logic                 r_ca, n_ca, r_rb, n_rb, cur_ca, cur_rb;
    logic [2*CB-1:0]      r_store [DEPTH];
    logic [2*CB-1:0]      r_mem_q;
    logic                 r_rd_vld;
    logic [AW-1:0]        mem_addr;
    logic                 mem_we, mem_re, acc_clr;
    logic signed [SW-1:0] r_acc_re, r_acc_im;
    logic signed [HW+17:0] r_ph_re, r_ph_im;
    logic [33:0]          r_pl_re, r_pl_im;
    logic                 load_err, load_res, out_free;
    logic                 more_col, more_row;
    logic [SIZE_W-1:0]    sel_col, sel_row;
    logic [CB:0]          rs_re, rs_im;
    logic                 r_o_vld, r_o_err, r_o_sat;
    logic [COEF_W-1:0]    r_o_re, r_o_im;

    // Round to nearest (ties up) and clip to the coefficient range; MSB flags a clip
    function automatic logic [CB:0] round_sat(input logic signed [HW+17:0] ph,
                                              input logic [33:0] pl);
        logic signed [PW-1:0] p;
        logic signed [QW-1:0] q;
        logic [CB:0]          r;
        p = (PW'(ph) <<< 17) + PW'(pl) + RND_HALF;
        q = p[PW-1:16];
        if (q > SAT_MAX)      r = {1'b1, SAT_MAX[CB-1:0]};
        else if (q < SAT_MIN) r = {1'b1, SAT_MIN[CB-1:0]};
        else                  r = {1'b0, q[CB-1:0]};
        return r;
    endfunction

    // Current command: queue head while idle, latched copy afterwards
    assign cur      = (r_state == ST_IDLE) ? i_q_cmd : r_cmd;
    assign cur_ca   = (r_state == ST_IDLE) ? 1'b0 : r_ca;
    assign cur_rb   = (r_state == ST_IDLE) ? 1'b0 : r_rb;
    assign sel_col  = cur_ca ? cur.col1 : cur.col0;
    assign sel_row  = cur_rb ? cur.row1 : cur.row0;
    assign mem_addr = {RW'(sel_row), CW'(sel_col)};
    assign more_col = !cur_ca && cur.fold_col;
    assign more_row = !cur_rb && cur.fold_row;
    assign out_free = !r_o_vld || o_out_ch.ready;

    // Sequencer: next state and strobes
    always_comb begin
        n_state  = r_state;
        n_ca     = r_ca;
        n_rb     = r_rb;
        o_q_pop  = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        acc_clr  = 1'b0;
        load_err = 1'b0;
        load_res = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    case (i_q_cmd.kind)
                        CMD_WRITE: begin
                            mem_we  = 1'b1;
                            o_q_pop = 1'b1;
                        end
                        CMD_READ: begin
                            mem_re  = 1'b1;
                            o_q_pop = 1'b1;
                            acc_clr = 1'b1;
                        end
                        CMD_ERROR: begin
                            if (out_free) begin
                                o_q_pop  = 1'b1;
                                load_err = 1'b1;
                            end
                        end
                        default: o_q_pop = 1'b1;
                    endcase
                end
            end
            ST_FETCH: mem_re  = 1'b1;
            ST_DRAIN: n_state = ST_MUL;
            ST_MUL:   n_state = ST_RND;
            ST_RND: begin
                if (out_free) begin
                    load_res = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        // Step to the next bin after each store read
        if (mem_re) begin
            if (more_col) begin
                n_ca    = 1'b1;
                n_state = ST_FETCH;
            end else if (more_row) begin
                n_ca    = 1'b0;
                n_rb    = 1'b1;
                n_state = ST_FETCH;
            end else begin
                n_ca    = 1'b0;
                n_rb    = 1'b0;
                n_state = ST_DRAIN;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ca     <= 1'b0;
            r_rb     <= 1'b0;
            r_rd_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ca     <= n_ca;
            r_rb     <= n_rb;
            r_rd_vld <= mem_re;
            if (load_err || load_res) r_o_vld <= 1'b1;
            else if (o_out_ch.ready)  r_o_vld <= 1'b0;
        end
    end

    // Coefficient store, single port
    always_ff @(posedge i_clk) begin
        if (mem_we) r_store[mem_addr] <= {i_q_cmd.coef_re[CB-1:0], i_q_cmd.coef_im[CB-1:0]};
        if (mem_re) r_mem_q <= r_store[mem_addr];
    end

    // Command latch, accumulation and partial products
    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_cmd <= i_q_cmd;
        if (acc_clr) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_rd_vld) begin
            r_acc_re <= r_acc_re + SW'($signed(r_mem_q[2*CB-1:CB]));
            r_acc_im <= r_acc_im + SW'($signed(r_mem_q[CB-1:0]));
        end
        if (r_state == ST_MUL) begin
            r_ph_re <= (HW+18)'($signed(r_acc_re[SW-1:17])) *
                       $signed((HW+18)'({1'b0, i_scale}));
            r_ph_im <= (HW+18)'($signed(r_acc_im[SW-1:17])) *
                       $signed((HW+18)'({1'b0, i_scale}));
            r_pl_re <= 34'(r_acc_re[16:0]) * 34'(i_scale);
            r_pl_im <= 34'(r_acc_im[16:0]) * 34'(i_scale);
        end
    end

    assign rs_re = round_sat(r_ph_re, r_pl_re);
    assign rs_im = round_sat(r_ph_im, r_pl_im);

    // Output register
    always_ff @(posedge i_clk) begin
        if (load_err) begin
            r_o_re  <= '0;
            r_o_im  <= '0;
            r_o_err <= 1'b1;
            r_o_sat <= 1'b0;
        end else if (load_res) begin
            r_o_re  <= COEF_W'($signed(rs_re[CB-1:0]));
            r_o_im  <= COEF_W'($signed(rs_im[CB-1:0]));
            r_o_err <= 1'b0;
            r_o_sat <= rs_re[CB] || rs_im[CB];
        end
    end

    assign o_out_ch.valid       = r_o_vld;
    assign o_out_ch.out_re      = r_o_re;
    assign o_out_ch.out_im      = r_o_im;
    assign o_out_ch.coord_error = r_o_err;
    assign o_out_ch.saturated   = r_o_sat;

`ifndef ASSERT_OFF
    a_rd_in_gather: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == ST_FETCH || r_state == ST_DRAIN))
        else $error("store data returned outside the gather phase");
    a_drain_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DRAIN |-> r_rd_vld)
        else $error("drain without a pending store read");
    a_mul_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MUL |-> $past(r_state) == ST_DRAIN)
        else $error("scaling started before the sum was complete");
`endif

endmodule
